/* src/pks_pkg.sv */
// ----------------------------------------------------------------------------
// pks_pkg: shared types and constants
// Widths, controller commands and status for the preemptive key scheduler.
// ----------------------------------------------------------------------------
package pks_pkg;

  localparam int MaxTasks = 16;
  localparam int IdW = 4;
  localparam int BurstW = 16;
  localparam int PrioW = 8;
  localparam int TimeW = 32;
  localparam int OvhW = 8;

  localparam logic [1:0] CPU_IDLE = 2'd0;
  localparam logic [1:0] CPU_RUN = 2'd1;
  localparam logic [1:0] CPU_SWITCH = 2'd2;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ARRIVE = 1'b1;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_OVERHEAD = 1'b1;

  typedef struct packed {
    logic load;     // latch the accepted transaction and do its work
    logic scan_clr; // start the dispatch scan
    logic scan_step;// examine one table entry
    logic scan_end; // commit scan result
  } pks_cmd_t;

  typedef struct packed {
    logic need_scan; // a completion left the cpu free
    logic scan_last; // scan index at last entry
  } pks_stat_t;

endpackage

/* src/pks_ctrl.sv */
// ----------------------------------------------------------------------------
// pks_ctrl: sequencing state machine
// Accepts one transaction, runs the dispatch scan when needed, holds result.
// ----------------------------------------------------------------------------
module pks_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pks_pkg::pks_cmd_t   cmd,
  input  pks_pkg::pks_stat_t  stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.need_scan) begin
          cmd.scan_clr = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          cmd.scan_end = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.scan_last) |=> state == S_OUT)
    else $error("scan did not finish into output");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");
  a_load_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DEC)
    else $error("load not followed by decode");

endmodule

/* src/pks_dp.sv */
// ----------------------------------------------------------------------------
// pks_dp: scheduler datapath
// Task table, time counter, current task, one-entry-per-cycle minimum scan.
// ----------------------------------------------------------------------------
module pks_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pks_pkg::pks_cmd_t                 cmd,
  output pks_pkg::pks_stat_t                stat,
  input  logic                              cfg_we,
  input  logic                              cfg_idx,
  input  logic [pks_pkg::OvhW-1:0]          cfg_data,
  input  logic                              mode,
  input  logic [pks_pkg::IdW-1:0]           task_id,
  input  logic [pks_pkg::BurstW-1:0]        burst_len,
  input  logic [pks_pkg::PrioW-1:0]         prio_level,
  output logic [1:0]                        cpu_state,
  output logic [pks_pkg::IdW-1:0]           running_task,
  output logic                              preempted,
  output logic                              arrival_error,
  output logic                              done_valid,
  output logic [pks_pkg::IdW-1:0]           done_task,
  output logic [pks_pkg::TimeW-1:0]         finish_time,
  output logic [pks_pkg::TimeW-1:0]         turnaround,
  output logic [pks_pkg::TimeW-1:0]         waiting
);

  localparam int N = pks_pkg::MaxTasks;

  logic policy;
  logic [pks_pkg::OvhW-1:0] ovh_cfg;
  logic [pks_pkg::TimeW-1:0] now_ticks;
  logic [pks_pkg::IdW-1:0] cur;
  logic cur_valid;
  logic [pks_pkg::OvhW-1:0] ovh_left;
  logic [N-1:0] active, ready;
  logic [pks_pkg::TimeW-1:0] stamp [N];
  logic [pks_pkg::BurstW-1:0] burst_st [N];
  logic [pks_pkg::BurstW-1:0] rem_st [N];
  logic [pks_pkg::PrioW-1:0] prio_st [N];
  logic need_scan;
  logic [pks_pkg::IdW-1:0] scan_idx, best;
  logic found;
  logic [pks_pkg::BurstW-1:0] best_key;

  function automatic logic [pks_pkg::BurstW-1:0] key_f(
    input logic pol, input logic [pks_pkg::BurstW-1:0] rem,
    input logic [pks_pkg::PrioW-1:0] pr);
    key_f = pol ? {{(pks_pkg::BurstW-pks_pkg::PrioW){1'b0}}, pr} : rem;
  endfunction

  logic [pks_pkg::BurstW-1:0] burst_fix, new_key, cur_key, scan_key;
  assign burst_fix = (burst_len == '0) ? pks_pkg::BurstW'(1) : burst_len;
  assign new_key = key_f(policy, burst_fix, prio_level);
  assign cur_key = key_f(policy, rem_st[cur], prio_st[cur]);
  assign scan_key = key_f(policy, rem_st[scan_idx], prio_st[scan_idx]);

  logic [pks_pkg::TimeW-1:0] now_inc, tat_c;
  assign now_inc = now_ticks + pks_pkg::TimeW'(1);
  assign tat_c = now_inc - stamp[cur];

  assign stat.need_scan = need_scan;
  assign stat.scan_last = (scan_idx == pks_pkg::IdW'(N-1));

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b0;
      ovh_cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == pks_pkg::CFG_POLICY) policy <= cfg_data[0];
      else ovh_cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
      cur <= '0;
      cur_valid <= 1'b0;
      ovh_left <= '0;
      active <= '0;
      ready <= '0;
      need_scan <= 1'b0;
      scan_idx <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.load) begin
        need_scan <= 1'b0;
        preempted <= 1'b0;
        arrival_error <= 1'b0;
        done_valid <= 1'b0;
        done_task <= '0;
        finish_time <= '0;
        turnaround <= '0;
        waiting <= '0;
        if (mode == pks_pkg::MODE_ARRIVE) begin
          if (active[task_id]) begin
            arrival_error <= 1'b1;
          end else begin
            active[task_id] <= 1'b1;
            stamp[task_id] <= now_ticks;
            burst_st[task_id] <= burst_fix;
            rem_st[task_id] <= burst_fix;
            prio_st[task_id] <= prio_level;
            if (!cur_valid) begin
              cur <= task_id;
              cur_valid <= 1'b1;
              ovh_left <= '0;
              ready[task_id] <= 1'b0;
            end else if (new_key < cur_key) begin
              ready[cur] <= 1'b1;
              ready[task_id] <= 1'b0;
              cur <= task_id;
              ovh_left <= ovh_cfg;
              preempted <= 1'b1;
            end else begin
              ready[task_id] <= 1'b1;
            end
          end
        end else begin
          now_ticks <= now_inc;
          if (!cur_valid) begin
            ovh_left <= '0;
          end else if (ovh_left != '0) begin
            ovh_left <= ovh_left - pks_pkg::OvhW'(1);
          end else if (rem_st[cur] <= pks_pkg::BurstW'(1)) begin
            rem_st[cur] <= '0;
            done_valid <= 1'b1;
            done_task <= cur;
            finish_time <= now_inc;
            turnaround <= tat_c;
            waiting <= tat_c - {{(pks_pkg::TimeW-pks_pkg::BurstW){1'b0}}, burst_st[cur]};
            active[cur] <= 1'b0;
            cur_valid <= 1'b0;
            cur <= '0;
            need_scan <= 1'b1;
          end else begin
            rem_st[cur] <= rem_st[cur] - pks_pkg::BurstW'(1);
          end
        end
      end
      if (cmd.scan_clr) begin
        scan_idx <= '0;
        found <= 1'b0;
      end
      if (cmd.scan_step) begin
        // strict compare keeps the lowest id among equal keys
        if (ready[scan_idx] && (!found || scan_key < best_key)) begin
          found <= 1'b1;
          best <= scan_idx;
          best_key <= scan_key;
        end
        scan_idx <= scan_idx + pks_pkg::IdW'(1);
      end
      if (cmd.scan_end) begin
        if (ready[scan_idx] && (!found || scan_key < best_key)) begin
          ready[scan_idx] <= 1'b0;
          cur <= scan_idx;
          cur_valid <= 1'b1;
          ovh_left <= ovh_cfg;
        end else if (found) begin
          ready[best] <= 1'b0;
          cur <= best;
          cur_valid <= 1'b1;
          ovh_left <= ovh_cfg;
        end else begin
          ovh_left <= '0;
        end
      end
    end
  end

  assign cpu_state = !cur_valid ? pks_pkg::CPU_IDLE :
                     (ovh_left != '0 ? pks_pkg::CPU_SWITCH : pks_pkg::CPU_RUN);
  assign running_task = cur_valid ? cur : '0;

  a_cur_active: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> active[cur])
    else $error("current task not active");
  a_cur_not_ready: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> !ready[cur])
    else $error("current task also in ready table");
  a_ready_active: assert property (@(posedge clk) disable iff (rst)
    (ready & ~active) == '0)
    else $error("ready bit on inactive task");

endmodule

/* src/preemptive_key_scheduler_core.sv */
// ----------------------------------------------------------------------------
// preemptive_key_scheduler_core: preemptive srtn / priority scheduler
// Tick and arrival transactions in, one status transaction out per input.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_ready  | mode, task_id, burst_len, prio_level
//   output   | out_valid / out_ready| cpu_state .. waiting
//   config   | cfg_we               | cfg_index, cfg_data
//
// an arrival or a tick without completion passes S_DEC and then offers its
// result in S_OUT; a completing tick adds a scan of the ready table in
// S_SCAN, one entry per cycle, between S_DEC and S_OUT. the block goes
// back to S_IDLE once the result is taken, and only then accepts input.
// a stalled result holds the block until taken. synchronous active high
// reset clears all control state; the task payload tables are written on
// arrival and read only while active.
// ----------------------------------------------------------------------------
module preemptive_key_scheduler_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [pks_pkg::IdW-1:0]    task_id,
  input  logic [pks_pkg::BurstW-1:0] burst_len,
  input  logic [pks_pkg::PrioW-1:0]  prio_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 cpu_state,
  output logic [pks_pkg::IdW-1:0]    running_task,
  output logic                       preempted,
  output logic                       arrival_error,
  output logic                       done_valid,
  output logic [pks_pkg::IdW-1:0]    done_task,
  output logic [pks_pkg::TimeW-1:0]  finish_time,
  output logic [pks_pkg::TimeW-1:0]  turnaround,
  output logic [pks_pkg::TimeW-1:0]  waiting,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pks_pkg::OvhW-1:0]   cfg_data
);

  // commands from the controller, status back from the datapath
  pks_pkg::pks_cmd_t  cmd;
  pks_pkg::pks_stat_t stat;

  pks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // task table, timer and scan live here
  pks_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .task_id       (task_id),
    .burst_len     (burst_len),
    .prio_level    (prio_level),
    .cpu_state     (cpu_state),
    .running_task  (running_task),
    .preempted     (preempted),
    .arrival_error (arrival_error),
    .done_valid    (done_valid),
    .done_task     (done_task),
    .finish_time   (finish_time),
    .turnaround    (turnaround),
    .waiting       (waiting)
  );

endmodule
